### rtl/aed_pkg.sv
// Shared constants for the envelope detector.
// No dependencies.
package aed_pkg;
   localparam int COEF_W = 17;
   localparam int OUT_W = 23;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam int RWIN_W = 11;
   localparam int LAHD_W = 12;

   localparam logic [COEF_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic [COEF_W-1:0] ROUND_Q16 = 17'd32768;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RMS_WIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 3'd4;

   localparam logic [RWIN_W-1:0] RMS_WIN_RESET = 11'd240;
   localparam logic [LAHD_W-1:0] LOOKAHEAD_RESET = 12'd480;
endpackage

### rtl/aed_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/aed_mean_root.sv
// Iterative window mean and square root: restoring divide, then bitwise root.
// No dependencies.
module aed_mean_root #(
   parameter int TOT_W = 56,
   parameter int LEN_W = 11,
   parameter int ROOT_W = 23
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TOT_W-1:0]  total,
   input  logic [LEN_W-1:0]  len,
   output logic              busy,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   localparam int CNT_W = $clog2(TOT_W + 1);
   localparam int B0 = 2 * ((TOT_W - 1) / 2);
   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_DIV = 2'd1;
   localparam logic [1:0] M_SQRT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TOT_W-1:0]  quo_ff, quo_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [TOT_W-1:0]  v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              done_ff, done_in;
   logic [LEN_W:0]    rem_sh, rem_sub;
   logic [TOT_W:0]    t_sum;
   logic [TOT_W-1:0]  r_next;

   assign rem_sh = {rem_ff, quo_ff[TOT_W-1]};
   assign rem_sub = rem_sh - {1'b0, len_ff};
   assign t_sum = {1'b0, r_ff} + {1'b0, b_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      len_in = len_ff;
      v_in = v_ff;
      r_in = r_ff;
      b_in = b_ff;
      root_in = root_ff;
      done_in = 1'b0;
      r_next = r_ff >> 1;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               quo_in = total;
               rem_in = '0;
               len_in = len;
               cnt_in = '0;
               state_in = M_DIV;
            end
         end
         M_DIV: begin
            quo_in = {quo_ff[TOT_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, len_ff}) begin
               rem_in = rem_sub[LEN_W-1:0];
               quo_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh[LEN_W-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TOT_W - 1)) begin
               v_in = quo_in;
               r_in = '0;
               b_in = TOT_W'(1) << B0;
               state_in = M_SQRT;
            end
         end
         M_SQRT: begin
            if ({1'b0, v_ff} >= t_sum) begin
               v_in = v_ff - t_sum[TOT_W-1:0];
               r_next = (r_ff >> 1) + b_ff;
            end
            r_in = r_next;
            b_in = b_ff >> 2;
            if (b_ff == TOT_W'(1)) begin
               if (r_next > TOT_W'({ROOT_W{1'b1}})) begin
                  root_in = {ROOT_W{1'b1}};
               end else begin
                  root_in = r_next[ROOT_W-1:0];
               end
               done_in = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      len_ff <= len_in;
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
      root_ff <= root_in;
   end

   assign busy = (state_ff != M_IDLE);
   assign done = done_ff;
   assign root = root_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == M_SQRT)
      else $error("root done without a root pass");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == M_IDLE && start) |=> state_ff == M_DIV)
      else $error("start not taken");
   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == M_DIV) |-> rem_ff < len_ff)
      else $error("remainder out of range");
endmodule

### rtl/audio_dynamics_envelope_detector.sv
// Envelope detector top level: frame peak, lookahead ring, smoothing, windowed RMS.
// Depends on aed_pkg, aed_ram, aed_mean_root.
// A plain sample only updates the frame peak; a frame-end word also runs the ring and
// smoothing steps, and every fourth one adds the shared divide and root and a result word.
// Throughput: one word at a time, plus any wait on a stalled result. Reset: synchronous;
// both rings are then zeroed one entry a cycle over max(LOOKAHEAD_DEPTH, RMS_DEPTH) entries.
module audio_dynamics_envelope_detector #(
   parameter int LOOKAHEAD_DEPTH = 2048,
   parameter int RMS_DEPTH = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample,
   input  logic                            req_last_of_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [aed_pkg::OUT_W-1:0]       rsp_envelope,
   output logic [aed_pkg::OUT_W-1:0]       rsp_rms_amplitude,
   output logic [aed_pkg::OUT_W-1:0]       rsp_peak_envelope,
   input  logic                            csr_write,
   input  logic [aed_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [aed_pkg::CSR_DATA_W-1:0]  csr_data
);
   import aed_pkg::*;

   localparam int MB = SAMPLE_BITS - 1;
   localparam int MUL_B_W = (MB > COEF_W) ? MB : COEF_W;
   localparam int PW = MB + MUL_B_W;
   localparam int ACC_W = 2 * MB + 2;
   localparam int MS_W = 2 * MB;
   localparam int LA_AW = $clog2(LOOKAHEAD_DEPTH);
   localparam int RMS_AW = $clog2(RMS_DEPTH);
   localparam int LAL_W = LA_AW + 1;
   localparam int LEN_W = RMS_AW + 1;
   localparam int TOT_W = (MS_W + RMS_AW > 64) ? 64 : MS_W + RMS_AW;
   localparam int CLR_N = (LOOKAHEAD_DEPTH > RMS_DEPTH) ? LOOKAHEAD_DEPTH : RMS_DEPTH;
   localparam int CLR_W = $clog2(CLR_N);

   localparam logic [3:0] S_CLR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD = 4'd2;
   localparam logic [3:0] S_WR = 4'd3;
   localparam logic [3:0] S_SQ = 4'd4;
   localparam logic [3:0] S_RE1 = 4'd5;
   localparam logic [3:0] S_RE2 = 4'd6;
   localparam logic [3:0] S_PE1 = 4'd7;
   localparam logic [3:0] S_PE2 = 4'd8;
   localparam logic [3:0] S_PEF = 4'd9;
   localparam logic [3:0] S_MS = 4'd10;
   localparam logic [3:0] S_RT = 4'd11;
   localparam logic [3:0] S_MX1 = 4'd12;
   localparam logic [3:0] S_MX2 = 4'd13;
   localparam logic [3:0] S_MX3 = 4'd14;

   logic [COEF_W-1:0] attack_ff, release_ff, mix_ff;
   logic [RWIN_W-1:0] rwin_ff;
   logic [LAHD_W-1:0] lahd_ff;

   logic [3:0]        state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [MB-1:0]     fpeak_ff, fpeak_in, lev_new_ff, lev_new_in, lev_old_ff, lev_old_in;
   logic [MS_W-1:0]   ms_old_ff, ms_old_in;
   logic [LA_AW-1:0]  la_pos_ff, la_pos_in;
   logic [RMS_AW-1:0] ms_pos_ff, ms_pos_in;
   logic [ACC_W-1:0]  accum_ff, accum_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [MB-1:0]     rms_lvl_ff, rms_lvl_in, rms_env_ff, rms_env_in, pk_env_ff, pk_env_in;
   logic [1:0]        phase_ff, phase_in;
   logic [PW-1:0]     prod_ff, acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  env_out_ff, env_out_in, rms_out_ff, rms_out_in, pk_out_ff, pk_out_in;

   logic [MB-1:0]      mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PW:0]        wsum;
   logic [MB-1:0]      wres;
   logic [COEF_W-1:0]  c_rms, c_pk, m_sat;
   logic [SAMPLE_BITS-1:0] neg_s;
   logic [MB-1:0]      mag;
   logic [MB-1:0]      peak_now;
   logic [LAL_W-1:0]   la_len;
   logic [LEN_W-1:0]   rms_len;
   logic [MS_W-1:0]    ms_new;
   logic               accept;

   logic               la_we, ms_we;
   logic [LA_AW-1:0]   la_waddr;
   logic [RMS_AW-1:0]  ms_waddr;
   logic [MB-1:0]      la_wdata, la_rdata;
   logic [MS_W-1:0]    ms_wdata, ms_rdata;
   logic               root_start, root_busy, root_done;
   logic [MB-1:0]      root_val;
   logic [63:0]        ext_env, ext_rms, ext_pk;

   function automatic logic [COEF_W-1:0] coef_sat(input logic [COEF_W-1:0] c);
      return (c > ONE_Q16) ? ONE_Q16 : c;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff <= '0;
         release_ff <= '0;
         mix_ff <= '0;
         rwin_ff <= RMS_WIN_RESET;
         lahd_ff <= LOOKAHEAD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ATTACK: attack_ff <= csr_data;
            CSR_RELEASE: release_ff <= csr_data;
            CSR_MIX: mix_ff <= csr_data;
            CSR_RMS_WIN: rwin_ff <= csr_data[RWIN_W-1:0];
            CSR_LOOKAHEAD: lahd_ff <= csr_data[LAHD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (lahd_ff == '0) begin
         la_len = LAL_W'(1);
      end else if (32'(lahd_ff) > LOOKAHEAD_DEPTH) begin
         la_len = LAL_W'(LOOKAHEAD_DEPTH);
      end else begin
         la_len = LAL_W'(lahd_ff);
      end
      if (rwin_ff == '0) begin
         rms_len = LEN_W'(1);
      end else if (32'(rwin_ff) > RMS_DEPTH) begin
         rms_len = LEN_W'(RMS_DEPTH);
      end else begin
         rms_len = LEN_W'(rwin_ff);
      end
   end

   assign neg_s = -req_sample;
   always_comb begin
      if (!req_sample[SAMPLE_BITS-1]) begin
         mag = req_sample[MB-1:0];
      end else if (neg_s[SAMPLE_BITS-1]) begin
         mag = {MB{1'b1}};
      end else begin
         mag = neg_s[MB-1:0];
      end
   end
   assign peak_now = (mag > fpeak_ff) ? mag : fpeak_ff;

   assign c_rms = coef_sat((rms_lvl_ff > rms_env_ff) ? attack_ff : release_ff);
   assign c_pk = coef_sat((lev_old_ff > pk_env_ff) ? attack_ff : release_ff);
   assign m_sat = coef_sat(mix_ff);

   always_comb begin
      mul_a = lev_new_ff;
      mul_b = MUL_B_W'(lev_new_ff);
      case (state_ff)
         S_RE1: begin
            mul_a = rms_env_ff;
            mul_b = MUL_B_W'(c_rms);
         end
         S_RE2: begin
            mul_a = rms_lvl_ff;
            mul_b = MUL_B_W'(ONE_Q16 - c_rms);
         end
         S_PE1: begin
            mul_a = pk_env_ff;
            mul_b = MUL_B_W'(c_pk);
         end
         S_PE2: begin
            mul_a = lev_old_ff;
            mul_b = MUL_B_W'(ONE_Q16 - c_pk);
         end
         S_MX1: begin
            mul_a = rms_env_ff;
            mul_b = MUL_B_W'(ONE_Q16 - m_sat);
         end
         S_MX2, S_MX3: begin
            mul_a = pk_env_ff;
            mul_b = MUL_B_W'(m_sat);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign wsum = {1'b0, acc_ff} + {1'b0, prod_ff} + (PW + 1)'(ROUND_Q16);
   assign wres = wsum[16 +: MB];
   assign ms_new = accum_ff[ACC_W-1:2];
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      fpeak_in = fpeak_ff;
      lev_new_in = lev_new_ff;
      lev_old_in = lev_old_ff;
      ms_old_in = ms_old_ff;
      la_pos_in = la_pos_ff;
      ms_pos_in = ms_pos_ff;
      accum_in = accum_ff;
      total_in = total_ff;
      rms_lvl_in = rms_lvl_ff;
      rms_env_in = rms_env_ff;
      pk_env_in = pk_env_ff;
      phase_in = phase_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      env_out_in = env_out_ff;
      rms_out_in = rms_out_ff;
      pk_out_in = pk_out_ff;
      la_we = 1'b0;
      ms_we = 1'b0;
      la_waddr = la_pos_ff;
      ms_waddr = ms_pos_ff;
      la_wdata = lev_new_ff;
      ms_wdata = ms_new;
      root_start = 1'b0;
      ext_env = '0;
      ext_rms = 64'(rms_lvl_ff);
      ext_pk = 64'(pk_env_ff);
      case (state_ff)
         S_CLR: begin
            la_we = 1'b1;
            ms_we = 1'b1;
            la_waddr = LA_AW'(clr_ff);
            ms_waddr = RMS_AW'(clr_ff);
            la_wdata = '0;
            ms_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_last_of_frame) begin
                  lev_new_in = peak_now;
                  fpeak_in = '0;
                  state_in = S_RD;
               end else begin
                  fpeak_in = peak_now;
               end
            end
         end
         S_RD: state_in = S_WR;
         S_WR: begin
            lev_old_in = la_rdata;
            ms_old_in = ms_rdata;
            la_we = 1'b1;
            if ({1'b0, la_pos_ff} + 1'b1 >= la_len) begin
               la_pos_in = '0;
            end else begin
               la_pos_in = la_pos_ff + 1'b1;
            end
            state_in = S_SQ;
         end
         S_SQ: state_in = S_RE1;
         S_RE1: begin
            accum_in = accum_ff + ACC_W'(prod_ff[MS_W-1:0]);
            state_in = S_RE2;
         end
         S_RE2: begin
            acc_in = prod_ff;
            state_in = S_PE1;
         end
         S_PE1: begin
            rms_env_in = wres;
            state_in = S_PE2;
         end
         S_PE2: begin
            acc_in = prod_ff;
            state_in = S_PEF;
         end
         S_PEF: begin
            pk_env_in = wres;
            phase_in = phase_ff + 1'b1;
            state_in = (phase_ff == 2'd3) ? S_MS : S_IDLE;
         end
         S_MS: begin
            total_in = total_ff - TOT_W'(ms_old_ff) + TOT_W'(ms_new);
            ms_we = 1'b1;
            accum_in = '0;
            if ({1'b0, ms_pos_ff} + 1'b1 >= rms_len) begin
               ms_pos_in = '0;
            end else begin
               ms_pos_in = ms_pos_ff + 1'b1;
            end
            root_start = 1'b1;
            state_in = S_RT;
         end
         S_RT: begin
            if (root_done) begin
               rms_lvl_in = root_val;
               state_in = S_MX1;
            end
         end
         S_MX1: state_in = S_MX2;
         S_MX2: begin
            acc_in = prod_ff;
            state_in = S_MX3;
         end
         S_MX3: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               ext_env = 64'(wres);
               env_out_in = ext_env[OUT_W-1:0];
               rms_out_in = ext_rms[OUT_W-1:0];
               pk_out_in = ext_pk[OUT_W-1:0];
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         fpeak_ff <= '0;
         la_pos_ff <= '0;
         ms_pos_ff <= '0;
         accum_ff <= '0;
         total_ff <= '0;
         rms_lvl_ff <= '0;
         rms_env_ff <= '0;
         pk_env_ff <= '0;
         phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fpeak_ff <= fpeak_in;
         la_pos_ff <= la_pos_in;
         ms_pos_ff <= ms_pos_in;
         accum_ff <= accum_in;
         total_ff <= total_in;
         rms_lvl_ff <= rms_lvl_in;
         rms_env_ff <= rms_env_in;
         pk_env_ff <= pk_env_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lev_new_ff <= lev_new_in;
      lev_old_ff <= lev_old_in;
      ms_old_ff <= ms_old_in;
      acc_ff <= acc_in;
      env_out_ff <= env_out_in;
      rms_out_ff <= rms_out_in;
      pk_out_ff <= pk_out_in;
   end

   aed_ram #(.WIDTH(MB), .DEPTH(LOOKAHEAD_DEPTH)) u_level_ring (
      .clock   (clock),
      .wr_en   (la_we),
      .wr_addr (la_waddr),
      .wr_data (la_wdata),
      .rd_addr (la_pos_ff),
      .rd_data (la_rdata)
   );

   aed_ram #(.WIDTH(MS_W), .DEPTH(RMS_DEPTH)) u_ms_ring (
      .clock   (clock),
      .wr_en   (ms_we),
      .wr_addr (ms_waddr),
      .wr_data (ms_wdata),
      .rd_addr (ms_pos_ff),
      .rd_data (ms_rdata)
   );

   aed_mean_root #(.TOT_W(TOT_W), .LEN_W(LEN_W), .ROOT_W(MB)) u_mean_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .total (total_in),
      .len   (rms_len),
      .busy  (root_busy),
      .done  (root_done),
      .root  (root_val)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_envelope = env_out_ff;
   assign rsp_rms_amplitude = rms_out_ff;
   assign rsp_peak_envelope = pk_out_ff;

   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_MX3)
      else $error("word presented outside mix step");
   a_accum_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MS |=> accum_ff == '0)
      else $error("square sum not cleared");
   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RT |-> phase_ff == 2'd0)
      else $error("window update off the fourth frame");
   a_root_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RT && !root_done |-> root_busy)
      else $error("waiting on an idle root unit");
endmodule

### verif/envelope_checker.sv
// Checker for the envelope detector: watches the sample, result and register ports.
// It predicts each result from its own model of the detector and compares them field by field.
// Depends on aed_pkg.
`timescale 1ns / 1ps
module envelope_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic signed [23:0]             req_sample,
   input  logic                           req_last_of_frame,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [aed_pkg::OUT_W-1:0]      rsp_envelope,
   input  logic [aed_pkg::OUT_W-1:0]      rsp_rms_amplitude,
   input  logic [aed_pkg::OUT_W-1:0]      rsp_peak_envelope,
   input  logic                           csr_write,
   input  logic [aed_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aed_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             mismatches,
   output int                             pending,
   output int                             results_seen
);
   import aed_pkg::*;

   localparam int LEVEL_DEPTH = 2048;
   localparam int MS_DEPTH = 1024;
   localparam bit [63:0] MAG_LIMIT = 64'd8388607;

   typedef struct packed {
      logic [OUT_W-1:0] env;
      logic [OUT_W-1:0] rms;
      logic [OUT_W-1:0] peak;
   } envelope_word_type;

   envelope_word_type envelope_due[$];

   logic [COEF_W-1:0] attack_q, release_q, mix_q;
   logic [RWIN_W-1:0] window_q;
   logic [LAHD_W-1:0] lookahead_q;

   bit [63:0] frame_max;
   bit [63:0] level_ring [LEVEL_DEPTH];
   int        level_pos;
   bit [63:0] square_sum;
   bit [63:0] ms_ring [MS_DEPTH];
   int        ms_pos;
   bit [63:0] ms_total;
   bit [63:0] rms_now, rms_smooth, peak_smooth;
   bit [1:0]  frame_count;

   assign pending = envelope_due.size();

   function automatic bit [63:0] clamp_coef(logic [COEF_W-1:0] c);
      return (c > ONE_Q16) ? 64'd65536 : 64'(c);
   endfunction

   function automatic int clamp_len(int n, int depth);
      if (n == 0) return 1;
      return (n > depth) ? depth : n;
   endfunction

   function automatic bit [63:0] smooth_level(bit [63:0] env, bit [63:0] x);
      bit [63:0] c;
      c = clamp_coef((x > env) ? attack_q : release_q);
      return (env * c + x * (64'd65536 - c) + 64'd32768) >> 16;
   endfunction

   function automatic bit [63:0] floor_root(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic advance_detector(logic signed [23:0] s, logic last);
      longint        sv;
      bit [63:0]     mag, lev_new, lev_old, ms, mix;
      int            len;
      envelope_word_type w;
      sv = s;
      mag = (sv < 0) ? 64'(-sv) : 64'(sv);
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      if (mag > frame_max) frame_max = mag;
      if (!last) return;
      lev_new = frame_max;
      frame_max = 0;
      len = clamp_len(int'(lookahead_q), LEVEL_DEPTH);
      level_pos = level_pos % LEVEL_DEPTH;
      lev_old = level_ring[level_pos];
      level_ring[level_pos] = lev_new;
      level_pos = (level_pos + 1 >= len) ? 0 : level_pos + 1;
      square_sum = square_sum + lev_new * lev_new;
      rms_smooth = smooth_level(rms_smooth, rms_now);
      peak_smooth = smooth_level(peak_smooth, lev_old);
      frame_count = frame_count + 2'd1;
      if (frame_count != 2'd0) return;
      ms = square_sum >> 2;
      square_sum = 0;
      len = clamp_len(int'(window_q), MS_DEPTH);
      ms_pos = ms_pos % MS_DEPTH;
      ms_total = ms_total - ms_ring[ms_pos] + ms;
      ms_ring[ms_pos] = ms;
      ms_pos = (ms_pos + 1 >= len) ? 0 : ms_pos + 1;
      rms_now = floor_root(ms_total / 64'(len));
      if (rms_now > MAG_LIMIT) rms_now = MAG_LIMIT;
      mix = clamp_coef(mix_q);
      w.env = OUT_W'((rms_smooth * (64'd65536 - mix) + peak_smooth * mix + 64'd32768) >> 16);
      w.rms = OUT_W'(rms_now);
      w.peak = OUT_W'(peak_smooth);
      envelope_due.push_back(w);
   endtask

   task automatic compare_word();
      envelope_word_type w;
      results_seen++;
      if (envelope_due.size() == 0) begin
         $display("%0t: unexpected result env=%0d rms=%0d peak=%0d", $time,
                  rsp_envelope, rsp_rms_amplitude, rsp_peak_envelope);
         mismatches++;
         return;
      end
      w = envelope_due.pop_front();
      if (rsp_envelope !== w.env) begin
         $display("%0t: envelope expected %0d got %0d", $time, w.env, rsp_envelope);
         mismatches++;
      end
      if (rsp_rms_amplitude !== w.rms) begin
         $display("%0t: rms_amplitude expected %0d got %0d", $time, w.rms, rsp_rms_amplitude);
         mismatches++;
      end
      if (rsp_peak_envelope !== w.peak) begin
         $display("%0t: peak_envelope expected %0d got %0d", $time, w.peak,
                  rsp_peak_envelope);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         attack_q <= '0;
         release_q <= '0;
         mix_q <= '0;
         window_q <= RMS_WIN_RESET;
         lookahead_q <= LOOKAHEAD_RESET;
         frame_max = 0;
         foreach (level_ring[i]) level_ring[i] = 0;
         foreach (ms_ring[i]) ms_ring[i] = 0;
         level_pos = 0;
         ms_pos = 0;
         square_sum = 0;
         ms_total = 0;
         rms_now = 0;
         rms_smooth = 0;
         peak_smooth = 0;
         frame_count = 0;
         envelope_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ATTACK:    attack_q <= csr_data;
               CSR_RELEASE:   release_q <= csr_data;
               CSR_MIX:       mix_q <= csr_data;
               CSR_RMS_WIN:   window_q <= csr_data[RWIN_W-1:0];
               CSR_LOOKAHEAD: lookahead_q <= csr_data[LAHD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) compare_word();
         if (req_valid && !req_stall) advance_detector(req_sample, req_last_of_frame);
      end
   end
endmodule

### verif/testbench.sv
// Top of the envelope detector testbench: clock, reset, sample and register stimulus, verdict.
// Depends on aed_pkg, audio_dynamics_envelope_detector and envelope_checker.
`timescale 1ns / 1ps
module testbench;
   import aed_pkg::*;

   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT = 2000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [23:0]    req_sample = '0;
   logic                  req_last_of_frame = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OUT_W-1:0]      rsp_envelope, rsp_rms_amplitude, rsp_peak_envelope;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ATTACK;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatches, pending, results_seen;
   int cycles = 0;
   int words_sent = 0;
   int frames_sent = 0;
   int settings_used = 0;
   int stall_pct = 0;
   bit no_gaps = 1'b0;

   always #4 clock = ~clock;

   audio_dynamics_envelope_detector dut (
      .clock, .reset, .req_valid, .req_stall, .req_sample, .req_last_of_frame,
      .rsp_valid, .rsp_stall, .rsp_envelope, .rsp_rms_amplitude, .rsp_peak_envelope,
      .csr_write, .csr_index, .csr_data
   );

   envelope_checker env_check (
      .clock, .reset, .req_valid, .req_stall, .req_sample, .req_last_of_frame,
      .rsp_valid, .rsp_stall, .rsp_envelope, .rsp_rms_amplitude, .rsp_peak_envelope,
      .csr_write, .csr_index, .csr_data, .mismatches, .pending, .results_seen
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // vary result back-pressure: calm, light, heavy, near-blocked stretches
   always @(negedge clock) begin
      if (cycles % 300 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 60;
            default: stall_pct = 95;
         endcase
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic send_word(logic signed [23:0] s, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_last_of_frame <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
      if (last) frames_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(int unsigned att, int unsigned rel, int unsigned mix,
                                int unsigned win, int unsigned look);
      write_reg(CSR_ATTACK, att);
      write_reg(CSR_RELEASE, rel);
      write_reg(CSR_MIX, mix);
      write_reg(CSR_RMS_WIN, win);
      write_reg(CSR_LOOKAHEAD, look);
      settings_used++;
   endtask

   function automatic logic signed [23:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         case ($urandom_range(0, 5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'sh800001;
            3: return 24'sd0;
            4: return 24'sd1;
            default: return -24'sd1;
         endcase
      end
      if (r < 35) return 24'($signed($urandom_range(0, 8191)) - 4096);
      return 24'($urandom);
   endfunction

   task automatic send_frames(int words);
      int n, k;
      n = 0;
      while (n < words) begin
         no_gaps = ($urandom_range(0, 9) == 0);
         k = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
         for (int i = 0; i < k; i++) send_word(pick_sample(), i == k - 1);
         n += k;
      end
      no_gaps = 1'b0;
   endtask

   int unsigned setting_list [7][5] = '{
      '{0, 0, 0, 1, 1},
      '{65536, 65536, 65536, 1024, 2048},
      '{131071, 131071, 131071, 0, 0},
      '{30000, 60000, 32768, 4, 3},
      '{500, 65000, 10000, 2047, 4095},
      '{65536, 0, 65536, 7, 17},
      '{45000, 12000, 50000, 3, 1}
   };

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      do @(posedge clock); while (req_stall);
      @(negedge clock);

      // extremes at reset settings: most negative, most positive, zero, unit steps
      send_word(24'sh800000, 1'b1);
      send_word(24'sh7FFFFF, 1'b1);
      send_word(24'sh800001, 1'b0);
      send_word(24'sd0, 1'b1);
      send_word(-24'sd1, 1'b0);
      send_word(24'sd1, 1'b1);
      send_word(24'sd0, 1'b1);
      send_word(24'sd0, 1'b0);
      send_word(24'sd0, 1'b1);
      drain_results();
      apply_setting(0, 65536, 65536, 1, 1);
      send_word(24'sh7FFFFF, 1'b1);
      send_word(24'sh800000, 1'b0);
      send_word(24'sd5, 1'b1);
      send_word(24'sd0, 1'b1);
      send_word(-24'sd3, 1'b1);
      send_word(24'sh123456, 1'b0);
      send_word(24'sh400000, 1'b1);
      send_word(24'sd0, 1'b1);
      send_word(24'sd0, 1'b1);
      send_word(24'sd0, 1'b1);
      drain_results();

      foreach (setting_list[p]) begin
         apply_setting(setting_list[p][0], setting_list[p][1], setting_list[p][2],
                       setting_list[p][3], setting_list[p][4]);
         send_frames(225);
         drain_results();
      end

      $display("Sent %0d samples in %0d frames across %0d register settings,",
               words_sent, frames_sent, settings_used + 1);
      $display("and checked %0d envelope results under random stalls and gaps.",
               results_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

### files.f
rtl/aed_pkg.sv
rtl/aed_ram.sv
rtl/aed_mean_root.sv
rtl/audio_dynamics_envelope_detector.sv
verif/envelope_checker.sv
verif/testbench.sv
